### hw/rtl/lpmr_pkg.sv
// Shared types, codes and defaults of the length-prefixed message ring.
package lpmr_pkg;

  localparam int DEPTH_DEF        = 4096;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int LEN_W            = 12;
  localparam int HDR_CNT_W        = 2;

  localparam logic [1:0] FUNC_PUSH_BEGIN = 2'd0;
  localparam logic [1:0] FUNC_PUSH_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_PULL_BYTE  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR      = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EMPTY     = 3'd2;
  localparam logic [2:0] ST_NO_PUSH   = 3'd3;
  localparam logic [2:0] ST_PUSH_OPEN = 3'd4;

  typedef struct packed {
    logic [1:0]       func;
    logic [LEN_W-1:0] msg_len;
    logic [7:0]       data_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [7:0]       data_out;
    logic [LEN_W-1:0] pulled_len;
    logic             last;
    logic [LEN_W-1:0] used_bytes;
    logic [LEN_W-1:0] free_bytes;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] used;
    logic [LEN_W-1:0] free;
    logic             room_ok;
  } occ_t;

endpackage

### hw/rtl/lpmr_occ.sv
// Ring occupancy: used and free byte counts and the room check for a new message.
module lpmr_occ #(
  parameter int DEPTH        = lpmr_pkg::DEPTH_DEF,
  parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF,
  parameter int AW           = $clog2(DEPTH)
) (
  input  logic [AW-1:0]              read_ptr,
  input  logic [AW-1:0]              write_ptr,
  input  logic [AW-1:0]              commit_ptr,
  input  logic [lpmr_pkg::LEN_W-1:0] msg_len,
  output lpmr_pkg::occ_t             occ
);

  localparam int XW = (AW > lpmr_pkg::LEN_W) ? AW : lpmr_pkg::LEN_W;
  localparam int CW = XW + 2;

  logic [AW:0]   used_w, held_w;
  logic [AW-1:0] used, held, room;
  logic [XW-1:0] used_x, free_x;
  logic [CW-1:0] room_c, need_c;

  always_comb begin
    if (commit_ptr >= read_ptr) begin
      used_w = {1'b0, commit_ptr} - {1'b0, read_ptr};
    end else begin
      used_w = {1'b0, commit_ptr} + (AW+1)'(DEPTH) - {1'b0, read_ptr};
    end
    if (write_ptr >= read_ptr) begin
      held_w = {1'b0, write_ptr} - {1'b0, read_ptr};
    end else begin
      held_w = {1'b0, write_ptr} + (AW+1)'(DEPTH) - {1'b0, read_ptr};
    end
    used   = used_w[AW-1:0];
    held   = held_w[AW-1:0];
    room   = AW'(DEPTH - 1) - held;
    used_x = XW'(used);
    free_x = XW'(room);
    room_c = CW'(room);
    need_c = CW'(msg_len) + CW'(HEADER_BYTES);
    occ.used    = used_x[lpmr_pkg::LEN_W-1:0];
    occ.free    = free_x[lpmr_pkg::LEN_W-1:0];
    occ.room_ok = (room_c >= need_c);
  end

endmodule

### hw/rtl/length_prefixed_message_ring_core.sv
// Top level of the length-prefixed message ring: sequencer, byte store and pointers.
//
// Input channel in_valid/in_stall/in_item carries one request: push_begin (msg_len),
// push_byte (data_in), pull_byte or clear. Each request gives exactly one result on
// out_valid/out_stall/out_item with a status, the pulled byte and length, a last flag
// and the committed and free byte counts after the request.
// One request is worked on at a time; in_stall is high until its result is loaded.
// Steps per request: push_byte, clear and rejected requests go from idle straight
// to the final state; push_begin writes one header byte per cycle in S_HDR_WR;
// a pull_byte inside a message reads one byte through S_RD and S_CAP; the first
// pull of a message reads each header byte through S_RD and S_CAP, then the
// first data byte the same way, unless the message is empty.
// The byte store has one write and one registered read port; a read passes through
// S_RD and S_CAP, and all pointer steps go through a single wrapping incrementer.
// A finished result sits in the output register until taken; while out_stall holds
// it, the next result waits in its final state and no new request is taken.
// Reset (rst_n low, synchronous) clears pointers, counters and the sequencer; the
// store is not cleared. A clear request clears the pointers and length counters only.
module length_prefixed_message_ring_core #(
  parameter int DEPTH        = lpmr_pkg::DEPTH_DEF,
  parameter int HEADER_BYTES = lpmr_pkg::HEADER_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lpmr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output lpmr_pkg::out_item_t out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = lpmr_pkg::LEN_W;
  localparam int CNW = lpmr_pkg::HDR_CNT_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_HDR_WR = 3'd1;
  localparam logic [2:0] S_RD     = 3'd2;
  localparam logic [2:0] S_CAP    = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] read_ptr_r, read_ptr_nxt;
  logic [AW-1:0] write_ptr_r, write_ptr_nxt;
  logic [AW-1:0] commit_ptr_r, commit_ptr_nxt;
  logic [LW-1:0] push_left_r, push_left_nxt;
  logic [LW-1:0] pull_left_r, pull_left_nxt;
  logic [LW-1:0] pull_len_r, pull_len_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] hdr_r, hdr_nxt, hdr_full;
  logic [CNW-1:0] hdr_cnt_r, hdr_cnt_nxt;
  logic          rd_hdr_r, rd_hdr_nxt;
  logic [2:0]    res_status_r, res_status_nxt;
  logic [7:0]    res_data_r, res_data_nxt;
  logic [LW-1:0] res_plen_r, res_plen_nxt;
  logic          res_last_r, res_last_nxt;
  logic          out_valid_r, out_valid_nxt;
  lpmr_pkg::out_item_t out_r, out_nxt;

  logic [7:0]    mem [DEPTH];
  logic [7:0]    rd_data_r;
  logic          mem_we;
  logic [7:0]    mem_wd;

  logic          step_rd;
  logic [AW-1:0] step_in, step_out;
  logic          hdr_last;
  lpmr_pkg::occ_t occ;

  lpmr_occ #(
    .DEPTH        (DEPTH),
    .HEADER_BYTES (HEADER_BYTES),
    .AW           (AW)
  ) u_occ (
    .read_ptr   (read_ptr_r),
    .write_ptr  (write_ptr_r),
    .commit_ptr (commit_ptr_r),
    .msg_len    (in_item.msg_len),
    .occ        (occ)
  );

  // shared wrapping pointer step
  assign step_in  = step_rd ? read_ptr_r : write_ptr_r;
  assign step_out = (step_in == AW'(DEPTH - 1)) ? '0 : step_in + AW'(1);

  assign hdr_last  = (hdr_cnt_r == CNW'(HEADER_BYTES - 1));
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  always_comb begin
    unique case (hdr_cnt_r)
      CNW'(0):  hdr_full = {hdr_r[LW-1:8], rd_data_r};
      CNW'(1):  hdr_full = {rd_data_r[LW-9:0], hdr_r[7:0]};
      default:  hdr_full = hdr_r;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    read_ptr_nxt   = read_ptr_r;
    write_ptr_nxt  = write_ptr_r;
    commit_ptr_nxt = commit_ptr_r;
    push_left_nxt  = push_left_r;
    pull_left_nxt  = pull_left_r;
    pull_len_nxt   = pull_len_r;
    len_nxt        = len_r;
    hdr_nxt        = hdr_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    rd_hdr_nxt     = rd_hdr_r;
    res_status_nxt = res_status_r;
    res_data_nxt   = res_data_r;
    res_plen_nxt   = res_plen_r;
    res_last_nxt   = res_last_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;
    mem_we         = 1'b0;
    mem_wd         = in_item.data_in;
    step_rd        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          len_nxt        = in_item.msg_len;
          res_status_nxt = lpmr_pkg::ST_OK;
          res_data_nxt   = '0;
          res_plen_nxt   = '0;
          res_last_nxt   = 1'b0;
          state_nxt      = S_FIN;
          unique case (in_item.func)
            lpmr_pkg::FUNC_PUSH_BEGIN: begin
              if (push_left_r != '0) begin
                res_status_nxt = lpmr_pkg::ST_PUSH_OPEN;
              end else if (!occ.room_ok) begin
                res_status_nxt = lpmr_pkg::ST_FULL;
              end else begin
                push_left_nxt = in_item.msg_len;
                hdr_cnt_nxt   = '0;
                state_nxt     = S_HDR_WR;
              end
            end
            lpmr_pkg::FUNC_PUSH_BYTE: begin
              if (push_left_r == '0) begin
                res_status_nxt = lpmr_pkg::ST_NO_PUSH;
              end else begin
                mem_we        = 1'b1;
                write_ptr_nxt = step_out;
                push_left_nxt = push_left_r - LW'(1);
                if (push_left_r == LW'(1)) begin
                  commit_ptr_nxt = step_out;
                  res_last_nxt   = 1'b1;
                end
              end
            end
            lpmr_pkg::FUNC_PULL_BYTE: begin
              if (pull_left_r == '0) begin
                if (read_ptr_r == commit_ptr_r) begin
                  res_status_nxt = lpmr_pkg::ST_EMPTY;
                end else begin
                  rd_hdr_nxt  = 1'b1;
                  hdr_cnt_nxt = '0;
                  hdr_nxt     = '0;
                  state_nxt   = S_RD;
                end
              end else begin
                rd_hdr_nxt = 1'b0;
                state_nxt  = S_RD;
              end
            end
            default: begin
              read_ptr_nxt   = '0;
              write_ptr_nxt  = '0;
              commit_ptr_nxt = '0;
              push_left_nxt  = '0;
              pull_left_nxt  = '0;
              pull_len_nxt   = '0;
            end
          endcase
        end
      end
      S_HDR_WR: begin
        mem_we        = 1'b1;
        write_ptr_nxt = step_out;
        unique case (hdr_cnt_r)
          CNW'(0):  mem_wd = len_r[7:0];
          CNW'(1):  mem_wd = 8'(len_r[LW-1:8]);
          default:  mem_wd = '0;
        endcase
        if (hdr_last) begin
          if (len_r == '0) begin
            commit_ptr_nxt = step_out;
            res_last_nxt   = 1'b1;
          end
          state_nxt = S_FIN;
        end else begin
          hdr_cnt_nxt = hdr_cnt_r + CNW'(1);
        end
      end
      S_RD: begin
        step_rd      = 1'b1;
        read_ptr_nxt = step_out;
        state_nxt    = S_CAP;
      end
      S_CAP: begin
        if (rd_hdr_r) begin
          if (hdr_last) begin
            pull_len_nxt  = hdr_full;
            pull_left_nxt = hdr_full;
            if (hdr_full == '0) begin
              res_last_nxt = 1'b1;
              state_nxt    = S_FIN;
            end else begin
              rd_hdr_nxt = 1'b0;
              state_nxt  = S_RD;
            end
          end else begin
            hdr_nxt     = hdr_full;
            hdr_cnt_nxt = hdr_cnt_r + CNW'(1);
            state_nxt   = S_RD;
          end
        end else begin
          res_data_nxt  = rd_data_r;
          res_plen_nxt  = pull_len_r;
          pull_left_nxt = pull_left_r - LW'(1);
          res_last_nxt  = (pull_left_r == LW'(1));
          state_nxt     = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.status     = res_status_r;
          out_nxt.data_out   = res_data_r;
          out_nxt.pulled_len = res_plen_r;
          out_nxt.last       = res_last_r;
          out_nxt.used_bytes = occ.used;
          out_nxt.free_bytes = occ.free;
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      read_ptr_r   <= '0;
      write_ptr_r  <= '0;
      commit_ptr_r <= '0;
      push_left_r  <= '0;
      pull_left_r  <= '0;
      pull_len_r   <= '0;
      hdr_cnt_r    <= '0;
      rd_hdr_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_ptr_r   <= read_ptr_nxt;
      write_ptr_r  <= write_ptr_nxt;
      commit_ptr_r <= commit_ptr_nxt;
      push_left_r  <= push_left_nxt;
      pull_left_r  <= pull_left_nxt;
      pull_len_r   <= pull_len_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      rd_hdr_r     <= rd_hdr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r        <= len_nxt;
    hdr_r        <= hdr_nxt;
    res_status_r <= res_status_nxt;
    res_data_r   <= res_data_nxt;
    res_plen_r   <= res_plen_nxt;
    res_last_r   <= res_last_nxt;
    out_r        <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[write_ptr_r] <= mem_wd;
    end
    rd_data_r <= mem[read_ptr_r];
  end

  a_commit_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && push_left_r == '0) |-> (commit_ptr_r == write_ptr_r))
    else $error("commit pointer lags write pointer with no push open");

  a_pull_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && pull_left_r != '0) |-> (read_ptr_r != commit_ptr_r))
    else $error("message pull in progress with no committed bytes left");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside the final state");

endmodule
